>>> src/lcd_4bit_write_sequencer_macros.svh
// Assertion macros shared by the LCD write sequencer RTL.
`ifndef LCD_4BIT_WRITE_SEQUENCER_MACROS_SVH
`define LCD_4BIT_WRITE_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LCD4_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcd4 assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LCD4_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcd4 assertion failed");

`endif

>>> src/lcd4_pkg.sv
// Types, codes and constants of the LCD 4-bit write sequencer.
`timescale 1ns / 1ps
package lcd4_pkg;

  localparam logic [2:0] OP_CMD    = 3'd0;
  localparam logic [2:0] OP_DATA   = 3'd1;
  localparam logic [2:0] OP_CURSOR = 3'd2;
  localparam logic [2:0] OP_DEC    = 3'd3;
  localparam logic [2:0] OP_INIT   = 3'd4;

  localparam logic [2:0] ROW_2 = 3'd2;
  localparam logic [2:0] ROW_3 = 3'd3;
  localparam logic [2:0] ROW_4 = 3'd4;

  localparam logic [7:0] BASE_ROW_1 = 8'h80;
  localparam logic [7:0] BASE_ROW_2 = 8'hC0;
  localparam logic [7:0] BASE_ROW_3 = 8'h94;
  localparam logic [7:0] BASE_ROW_4 = 8'hD4;

  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_HOME  = 8'h02;
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

  localparam logic [1:0] DISP_TYPE_RESET = 2'd2;

  localparam logic [15:0] STROBE_GAP_US   = 16'd100;
  localparam logic [15:0] SLOW_CMD_US     = 16'd2000;
  localparam logic [15:0] INIT_SHORT_US   = 16'd5000;
  localparam logic [15:0] INIT_LONG_US    = 16'd50000;
  localparam logic [15:0] POWERUP_WAIT_US = 16'd40000;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] value;
    logic [5:0] column;
    logic [2:0] row;
  } in_item_t;

  typedef struct packed {
    logic        reg_select;
    logic [3:0]  nibble;
    logic [15:0] pre_wait_us;
    logic [15:0] post_wait_us;
    logic        last;
  } out_item_t;

  // Status from the decimal converter.
  typedef struct packed {
    logic       done;
    logic [3:0] tens;
    logic [3:0] units;
  } bcd_stat_t;

  // Power-up command list; slot four is the function set.
  function automatic logic [7:0] init_cmd(input logic [2:0] idx, input logic [1:0] disp);
    logic [7:0] c;
    unique case (idx)
      3'd0, 3'd1, 3'd2: c = 8'h03;
      3'd3:             c = 8'h02;
      3'd4:             c = 8'h20 | {4'b0000, disp, 2'b00};
      3'd5:             c = 8'h0C;
      3'd6:             c = 8'h01;
      default:          c = 8'h06;
    endcase
    return c;
  endfunction

endpackage

>>> src/lcd4_bin2bcd.sv
// Bit-serial binary to decimal converter: tens and units digits of a byte.
`timescale 1ns / 1ps
module lcd4_bin2bcd (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [7:0]           value,
  output lcd4_pkg::bcd_stat_t  stat
);

  logic [7:0] bin_r, bin_nxt;
  logic [3:0] tens_r, tens_nxt;
  logic [3:0] units_r, units_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       busy_r, busy_nxt;
  logic       done_r, done_nxt;
  logic [3:0] tens_adj, units_adj;

  // add-3 before each shift; the hundreds carry is simply dropped
  assign units_adj = (units_r >= 4'd5) ? units_r + 4'd3 : units_r;
  assign tens_adj  = (tens_r  >= 4'd5) ? tens_r  + 4'd3 : tens_r;

  always_comb begin
    bin_nxt   = bin_r;
    tens_nxt  = tens_r;
    units_nxt = units_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      bin_nxt   = value;
      tens_nxt  = 4'd0;
      units_nxt = 4'd0;
      cnt_nxt   = 3'd0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      bin_nxt   = {bin_r[6:0], 1'b0};
      units_nxt = {units_adj[2:0], bin_r[7]};
      tens_nxt  = {tens_adj[2:0], units_adj[3]};
      cnt_nxt   = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r   <= bin_nxt;
    tens_r  <= tens_nxt;
    units_r <= units_nxt;
  end

  assign stat.done  = done_r;
  assign stat.tens  = tens_r;
  assign stat.units = units_r;

endmodule

>>> src/lcd_4bit_write_sequencer.sv
// LCD 4-bit write sequencer: turns each request into a run of nibble strobes.
//
// Input channel in_valid/in_stall/in_data carries one request: command byte,
// data character, cursor move, two-digit decimal number or power-up sequence.
// Output channel out_valid/out_stall/out_data gives one item per strobe, high
// nibble first, with register select, pre/post waits in us and a last flag.
// cfg_wr_en/cfg_wr_data write the display type used by the init function set.
// One request at a time: in_stall is high from acceptance until the last
// strobe has been loaded into the output register.
// Strobes leave at one per cycle while out_stall is low; a decimal number
// first waits for its digits, which come from a bit-serial converter that
// shifts one bit per cycle. Acceptance sets the state register; the first
// strobe then goes into the output register, after the converter for decimal.
// Init gives 16 strobes, a byte request 2, a decimal request 4; unused
// opcodes are accepted and dropped. Holding out_stall while out_valid is
// high freezes the output register and the sequencer behind it. Synchronous
// reset empties the pipeline and sets the display type to two lines.
`timescale 1ns / 1ps
`include "lcd_4bit_write_sequencer_macros.svh"
module lcd_4bit_write_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lcd4_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lcd4_pkg::out_item_t  out_data,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_wr_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [2:0] op_r, op_nxt;
  logic [7:0] byte0_r, byte0_nxt;
  logic       rs_r, rs_nxt;
  logic [3:0] k_r, k_nxt;
  logic [3:0] last_k_r, last_k_nxt;
  logic [3:0] lo_r, lo_nxt;
  logic       slow_r, slow_nxt;
  logic [1:0] disp_r, disp_nxt;
  logic       out_valid_r, out_valid_nxt;
  lcd4_pkg::out_item_t out_r, out_nxt;

  logic                in_acc;
  logic                emit_go;
  logic                bcd_start;
  lcd4_pkg::bcd_stat_t bcd;
  logic [7:0]          row_base;
  logic [7:0]          cursor_byte;
  logic [2:0]          idx;
  logic [7:0]          byte_cur;
  logic [15:0]         extra_us;
  logic [15:0]         slow_us;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign bcd_start = in_acc && (in_data.opcode == lcd4_pkg::OP_DEC);
  assign emit_go   = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  lcd4_bin2bcd u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (bcd_start),
    .value (in_data.value),
    .stat  (bcd)
  );

  always_comb begin
    case (in_data.row)
      lcd4_pkg::ROW_2: row_base = lcd4_pkg::BASE_ROW_2;
      lcd4_pkg::ROW_3: row_base = lcd4_pkg::BASE_ROW_3;
      lcd4_pkg::ROW_4: row_base = lcd4_pkg::BASE_ROW_4;
      default:         row_base = lcd4_pkg::BASE_ROW_1;
    endcase
  end

  // base + column - 1, wrapping at 256
  assign cursor_byte = row_base + {2'b00, in_data.column} + 8'hFF;

  assign idx = k_r[3:1];

  always_comb begin
    case (op_r)
      lcd4_pkg::OP_DEC:  byte_cur = (idx == 3'd0) ? {lcd4_pkg::ASCII_DIGIT_HI, bcd.tens}
                                                  : {lcd4_pkg::ASCII_DIGIT_HI, bcd.units};
      lcd4_pkg::OP_INIT: byte_cur = lcd4_pkg::init_cmd(idx, disp_r);
      default:           byte_cur = byte0_r;
    endcase
  end

  always_comb begin
    if (op_r != lcd4_pkg::OP_INIT)
      extra_us = 16'd0;
    else if (idx < 3'd4)
      extra_us = lcd4_pkg::INIT_SHORT_US;
    else
      extra_us = lcd4_pkg::INIT_LONG_US;
  end

  assign slow_us = slow_r ? lcd4_pkg::SLOW_CMD_US : 16'd0;

  // next strobe: even step sends the high nibble and keeps the low one
  always_comb begin
    out_nxt.reg_select = rs_r;
    out_nxt.last       = (k_r == last_k_r);
    lo_nxt             = lo_r;
    slow_nxt           = slow_r;
    if (!k_r[0]) begin
      out_nxt.nibble       = byte_cur[7:4];
      out_nxt.pre_wait_us  = ((op_r == lcd4_pkg::OP_INIT) && (k_r == 4'd0))
                             ? lcd4_pkg::POWERUP_WAIT_US : 16'd0;
      out_nxt.post_wait_us = lcd4_pkg::STROBE_GAP_US;
      lo_nxt               = byte_cur[3:0];
      slow_nxt             = !rs_r && ((byte_cur == lcd4_pkg::CMD_CLEAR)
                                       || (byte_cur == lcd4_pkg::CMD_HOME));
    end else begin
      out_nxt.nibble       = lo_r;
      out_nxt.pre_wait_us  = 16'd0;
      out_nxt.post_wait_us = lcd4_pkg::STROBE_GAP_US + extra_us + slow_us;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    byte0_nxt     = byte0_r;
    rs_nxt        = rs_r;
    k_nxt         = k_r;
    last_k_nxt    = last_k_r;
    disp_nxt      = cfg_wr_en ? cfg_wr_data : disp_r;
    out_valid_nxt = out_valid_r;

    if (emit_go)
      out_valid_nxt = 1'b1;
    else if (!out_stall)
      out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_data.opcode;
          k_nxt     = 4'd0;
          byte0_nxt = (in_data.opcode == lcd4_pkg::OP_CURSOR) ? cursor_byte : in_data.value;
          rs_nxt    = (in_data.opcode == lcd4_pkg::OP_DATA)
                      || (in_data.opcode == lcd4_pkg::OP_DEC);
          case (in_data.opcode) inside
            lcd4_pkg::OP_CMD, lcd4_pkg::OP_DATA, lcd4_pkg::OP_CURSOR: begin
              last_k_nxt = 4'd1;
              state_nxt  = ST_EMIT;
            end
            lcd4_pkg::OP_DEC: begin
              last_k_nxt = 4'd3;
              state_nxt  = ST_CONV;
            end
            lcd4_pkg::OP_INIT: begin
              last_k_nxt = 4'd15;
              state_nxt  = ST_EMIT;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CONV: begin
        if (bcd.done)
          state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) begin
          k_nxt = k_r + 4'd1;
          if (k_r == last_k_r)
            state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= 4'd0;
      last_k_r    <= 4'd0;
      disp_r      <= lcd4_pkg::DISP_TYPE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      last_k_r    <= last_k_nxt;
      disp_r      <= disp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    byte0_r <= byte0_nxt;
    rs_r    <= rs_nxt;
    if (emit_go) begin
      out_r  <= out_nxt;
      lo_r   <= lo_nxt;
      slow_r <= slow_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `LCD4_ASSERT_IMPL(a_pre_only_init, out_valid && (out_data.pre_wait_us != 16'd0), (out_data.nibble == 4'h0) && !out_data.reg_select)
  `LCD4_ASSERT_NEXT(a_busy_after_req, in_acc && (in_data.opcode <= lcd4_pkg::OP_INIT), in_stall)
  `LCD4_ASSERT_IMPL(a_k_bound, state_r == ST_EMIT, k_r <= last_k_r)
  `LCD4_ASSERT_IMPL(a_bcd_in_conv, bcd.done, state_r == ST_CONV)
  `LCD4_ASSERT_NEXT(a_last_ends, emit_go && out_nxt.last, (state_r == ST_IDLE) && out_data.last)

endmodule
